@@ hw/rtl/hct_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hct_pkg: shared types and constants of the handheld console timer
// Register addresses, item kinds, period table and the counting step record.
// ----------------------------------------------------------------------------
package hct_pkg;

   localparam int OP_W      = 2;
   localparam int ADDR_W    = 16;
   localparam int BYTE_W    = 8;
   localparam int CSUB_W    = 11;   // stored counter subcount
   localparam int CWORK_W   = 12;   // subcount plus one tick of cycles
   localparam int DSUB_W    = 9;    // divider subcount plus one tick

   localparam logic [ADDR_W-1:0] ADDR_DIV = 16'hFF04;
   localparam logic [ADDR_W-1:0] ADDR_CNT = 16'hFF05;
   localparam logic [ADDR_W-1:0] ADDR_RLD = 16'hFF06;
   localparam logic [ADDR_W-1:0] ADDR_CTL = 16'hFF07;

   localparam logic [BYTE_W-1:0] UNMAPPED_DATA = 8'hFF;
   localparam logic [BYTE_W-1:0] COUNTER_TOP   = 8'hFF;
   localparam int                ENABLE_BIT    = 2;

   typedef enum logic [OP_W-1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      SEL_1024 = 2'd0,
      SEL_16   = 2'd1,
      SEL_64   = 2'd2,
      SEL_256  = 2'd3
   } period_sel_type;

   // One pass of the shared counting unit
   typedef struct packed {
      logic                 ge;
      logic                 wrap;
      logic [CWORK_W-1:0]   diff;
      logic [BYTE_W-1:0]    counter_next;
   } step_type;

   function automatic logic [CSUB_W-1:0] period_of(input logic [1:0] sel);
      logic [CSUB_W-1:0] p;
      unique case (period_sel_type'(sel))
         SEL_1024: p = 11'd1024;
         SEL_16:   p = 11'd16;
         SEL_64:   p = 11'd64;
         SEL_256:  p = 11'd256;
         default:  p = 11'd1024;
      endcase
      return p;
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/hct_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hct_req_if / hct_rsp_if: valid/ready channels of the timer
// Request items (tick, read, write) and result items (read data, interrupt).
// ----------------------------------------------------------------------------
interface hct_req_if;
   logic                   valid;
   logic                   ready;
   hct_pkg::op_type        op;
   logic [15:0]            address;
   logic [7:0]             write_data;
   logic [7:0]             elapsed_cycles;

   modport source (output valid, op, address, write_data, elapsed_cycles, input ready);
   modport sink   (input valid, op, address, write_data, elapsed_cycles, output ready);
endinterface

interface hct_rsp_if;
   logic                   valid;
   logic                   ready;
   logic [7:0]             read_data;
   logic                   irq_request;

   modport source (output valid, read_data, irq_request, input ready);
   modport sink   (input valid, read_data, irq_request, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/hct_count_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hct_count_unit: shared compare/subtract/increment step
// Checks whether one whole period is held, takes it off and steps the counter.
// ----------------------------------------------------------------------------
module hct_count_unit (
   input  wire logic [hct_pkg::CWORK_W-1:0] csub,
   input  wire logic [hct_pkg::CSUB_W-1:0]  period,
   input  wire logic [hct_pkg::BYTE_W-1:0]  counter,
   input  wire logic [hct_pkg::BYTE_W-1:0]  reload,
   output hct_pkg::step_type                step
);
   import hct_pkg::*;

   logic [CWORK_W-1:0] period_ext;

   assign period_ext = {1'b0, period};

   always_comb begin
      step.ge   = (csub >= period_ext);
      step.diff = csub - period_ext;
      step.wrap = (counter == COUNTER_TOP);
      step.counter_next = step.wrap ? reload : counter + 8'd1;
   end

endmodule
`default_nettype wire

@@ hw/rtl/handheld_console_timer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// handheld_console_timer: divider / counter / reload / control timer
// Bus-mapped timer stepped by tick items, with an overflow interrupt flag.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one item: a tick of elapsed_cycles, a read or a write of
//   the registers at 0xFF04..0xFF07. rsp_chan returns exactly one item per
//   request: read_data on a read (0xFF when unmapped), irq_request on a tick.
//   One item is in flight at a time; req_chan.ready is high only when idle.
//   Read, write and disabled-timer tick items pass through S_EXEC and S_DONE
//   to the result register; a new item is taken only after the last one has
//   moved from S_DONE to the output register. An enabled tick also loops in
//   S_LOOP, stepping the counter up to 16 times normally (at most 79 after the
//   period is shortened): the single compare/subtract unit takes one period
//   off the subcount per cycle.
//   The result sits in an output register; if the receiver stalls, the next
//   request is still taken and runs, and only its hand-over to the output
//   register waits until the old result is taken.
//   Synchronous reset clears all timer registers and empties the result
//   register.
// ----------------------------------------------------------------------------
module handheld_console_timer (
   input  wire logic  clock,
   input  wire logic  reset,
   hct_req_if.sink    req_chan,
   hct_rsp_if.source  rsp_chan
);
   import hct_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_LOOP,
      S_DONE
   } state_type;

   state_type           state_ff, state_in;

   // latched item
   op_type              op_ff, op_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [BYTE_W-1:0]   wdata_ff, wdata_in;
   logic [BYTE_W-1:0]   cycles_ff, cycles_in;

   // timer registers
   logic [BYTE_W-1:0]   div_ff, div_in;
   logic [BYTE_W-1:0]   div_sub_ff, div_sub_in;
   logic [BYTE_W-1:0]   counter_ff, counter_in;
   logic [BYTE_W-1:0]   reload_ff, reload_in;
   logic [BYTE_W-1:0]   control_ff, control_in;
   logic [CSUB_W-1:0]   csub_ff, csub_in;

   logic [CWORK_W-1:0]  work_ff, work_in;
   logic [BYTE_W-1:0]   rdata_ff, rdata_in;
   logic                irq_ff, irq_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                rsp_irq_ff, rsp_irq_in;

   logic [DSUB_W-1:0]   dsum;
   logic                out_free;
   step_type            step;

   hct_count_unit u_count (
      .csub    (work_ff),
      .period  (period_of(control_ff[1:0])),
      .counter (counter_ff),
      .reload  (reload_ff),
      .step    (step)
   );

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.read_data    = rsp_data_ff;
   assign rsp_chan.irq_request  = rsp_irq_ff;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign dsum     = {1'b0, div_sub_ff} + {1'b0, cycles_ff};

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      wdata_in     = wdata_ff;
      cycles_in    = cycles_ff;
      div_in       = div_ff;
      div_sub_in   = div_sub_ff;
      counter_in   = counter_ff;
      reload_in    = reload_ff;
      control_in   = control_ff;
      csub_in      = csub_ff;
      work_in      = work_ff;
      rdata_in     = rdata_ff;
      irq_in       = irq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      rsp_irq_in   = rsp_irq_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in     = req_chan.op;
               addr_in   = req_chan.address;
               wdata_in  = req_chan.write_data;
               cycles_in = req_chan.elapsed_cycles;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            rdata_in = '0;
            irq_in   = 1'b0;
            state_in = S_DONE;
            unique case (op_ff)
               OP_TICK: begin
                  div_sub_in = dsum[BYTE_W-1:0];
                  if (dsum[BYTE_W]) begin
                     div_in = div_ff + 8'd1;
                  end
                  work_in = {1'b0, csub_ff} + {4'b0, cycles_ff};
                  if (control_ff[ENABLE_BIT]) begin
                     state_in = S_LOOP;
                  end
               end
               OP_READ: begin
                  unique case (addr_ff)
                     ADDR_DIV: rdata_in = div_ff;
                     ADDR_CNT: rdata_in = counter_ff;
                     ADDR_RLD: rdata_in = reload_ff;
                     ADDR_CTL: rdata_in = control_ff;
                     default:  rdata_in = UNMAPPED_DATA;
                  endcase
               end
               OP_WRITE: begin
                  unique case (addr_ff)
                     ADDR_DIV: begin
                        div_in     = '0;
                        div_sub_in = '0;
                     end
                     ADDR_CNT: counter_in = wdata_ff;
                     ADDR_RLD: reload_in  = wdata_ff;
                     ADDR_CTL: control_in = wdata_ff;
                     default:  ;
                  endcase
               end
               OP_NONE: ;
               default: ;
            endcase
         end
         S_LOOP: begin
            if (step.ge) begin
               work_in    = step.diff;
               counter_in = step.counter_next;
               irq_in     = irq_ff | step.wrap;
            end else begin
               csub_in  = work_ff[CSUB_W-1:0];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rdata_ff;
               rsp_irq_in   = irq_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_ff       <= '0;
         div_sub_ff   <= '0;
         counter_ff   <= '0;
         reload_ff    <= '0;
         control_ff   <= '0;
         csub_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_ff       <= div_in;
         div_sub_ff   <= div_sub_in;
         counter_ff   <= counter_in;
         reload_ff    <= reload_in;
         control_ff   <= control_in;
         csub_ff      <= csub_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      addr_ff     <= addr_in;
      wdata_ff    <= wdata_in;
      cycles_ff   <= cycles_in;
      work_ff     <= work_in;
      rdata_ff    <= rdata_in;
      irq_ff      <= irq_in;
      rsp_data_ff <= rsp_data_in;
      rsp_irq_ff  <= rsp_irq_in;
   end

endmodule
`default_nettype wire

@@ hw/rtl/hct_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hct_checker: port-level checks on the timer
// Watches the request and result channels; bound to the top level below.
// ----------------------------------------------------------------------------
module hct_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  read_data,
   input wire logic        irq_request
);

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result register not empty after reset");

   // one item at a time: no second acceptance right after one
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while an item is in flight");

   // an interrupt only comes with a tick, whose read data is zero
   a_irq_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && irq_request) |-> (read_data == 8'h00))
      else $error("interrupt result carries read data");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(read_data) && $stable(irq_request)))
      else $error("stalled result changed");

endmodule

bind handheld_console_timer hct_checker u_hct_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .read_data   (rsp_chan.read_data),
   .irq_request (rsp_chan.irq_request)
);
`default_nettype wire

@@ bench/handheld_console_timer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handheld_console_timer_test: self-checking bench for the console timer
// Drives tick, read, write and unused items with random gaps and a randomly
// stalling result side. Each accepted item updates a local copy of the timer
// registers; every result is checked in order against that prediction.
// ----------------------------------------------------------------------------
module handheld_console_timer_test;
   import hct_pkg::*;

   localparam int CLOCK_HALF   = 5;
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_ITEMS = 950;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 120;   // well beyond the longest enabled tick
   localparam int PRINT_CAP    = 200;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_request;
   } timer_result_type;

   // Tracks the timer registers and the results they imply, oldest first
   class timer_scoreboard;
      logic [7:0]         div_value;
      logic [7:0]         div_sub;
      logic [7:0]         cnt_value;
      logic [7:0]         rld_value;
      logic [7:0]         ctl_value;
      logic [10:0]        cnt_sub;
      timer_result_type   awaited_results[$];

      function new();
         div_value = '0;
         div_sub   = '0;
         cnt_value = '0;
         rld_value = '0;
         ctl_value = '0;
         cnt_sub   = '0;
      endfunction

      function logic advance_timer(logic [7:0] cycles);
         int unsigned dsum;
         int unsigned csum;
         int unsigned period;
         logic        wrapped;
         wrapped = 1'b0;
         dsum = div_sub + cycles;
         if (dsum >= 256) begin
            dsum -= 256;
            div_value++;
         end
         div_sub = dsum[7:0];
         if (!ctl_value[ENABLE_BIT])
            return 1'b0;   // stopped counter keeps its subcount
         case (period_sel_type'(ctl_value[1:0]))
            SEL_1024: period = 1024;
            SEL_16:   period = 16;
            SEL_64:   period = 64;
            default:  period = 256;
         endcase
         csum = cnt_sub + cycles;
         while (csum >= period) begin
            csum -= period;
            if (cnt_value == COUNTER_TOP) begin
               cnt_value = rld_value;
               wrapped   = 1'b1;
            end else begin
               cnt_value++;
            end
         end
         cnt_sub = csum[10:0];
         return wrapped;
      endfunction

      function void note_request(op_type op, logic [15:0] addr, logic [7:0] wdata,
                                 logic [7:0] cycles);
         timer_result_type res;
         res = '0;
         case (op)
            OP_TICK: res.irq_request = advance_timer(cycles);
            OP_READ: begin
               case (addr)
                  ADDR_DIV: res.read_data = div_value;
                  ADDR_CNT: res.read_data = cnt_value;
                  ADDR_RLD: res.read_data = rld_value;
                  ADDR_CTL: res.read_data = ctl_value;
                  default:  res.read_data = UNMAPPED_DATA;
               endcase
            end
            OP_WRITE: begin
               case (addr)
                  ADDR_DIV: begin
                     div_value = '0;
                     div_sub   = '0;
                  end
                  ADDR_CNT: cnt_value = wdata;
                  ADDR_RLD: rld_value = wdata;
                  ADDR_CTL: ctl_value = wdata;
                  default: ;
               endcase
            end
            default: ;
         endcase
         awaited_results.push_back(res);
      endfunction

      function bit check_response(logic [7:0] rd, logic irq, output string why);
         timer_result_type exp_res;
         why = "";
         if (awaited_results.size() == 0) begin
            why = $sformatf("result rd=%02h irq=%0b with nothing outstanding", rd, irq);
            return 1'b0;
         end
         exp_res = awaited_results.pop_front();
         if (rd !== exp_res.read_data)
            why = $sformatf("read_data %02h, expected %02h ", rd, exp_res.read_data);
         if (irq !== exp_res.irq_request)
            why = {why, $sformatf("irq_request %0b, expected %0b", irq, exp_res.irq_request)};
         return why == "";
      endfunction

      function int pending();
         return awaited_results.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   mismatches;
   int   cycle_count;
   int   send_burst;
   timer_scoreboard sb = new();

   hct_req_if req_chan ();
   hct_rsp_if rsp_chan ();

   handheld_console_timer uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   task automatic report_mismatch(string why);
      mismatches++;
      // past the cap, mismatches are only counted
      if (mismatches <= PRINT_CAP)
         $display("MISMATCH at %0t: %s", $time, why);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Mostly short gaps, a few long ones, and now and then a run with none
   function automatic int pick_send_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (send_burst > 0) begin
         send_burst--;
         return 0;
      end
      if (r < 3) begin
         send_burst = $urandom_range(20, 60);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_item(op_type op, logic [15:0] addr, logic [7:0] wdata,
                            logic [7:0] cycles);
      int gap;
      req_chan.valid          <= 1'b1;
      req_chan.op             <= op;
      req_chan.address        <= addr;
      req_chan.write_data     <= wdata;
      req_chan.elapsed_cycles <= cycles;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(op, addr, wdata, cycles);
      gap = pick_send_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic do_tick(logic [7:0] cycles);
      send_item(OP_TICK, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), cycles);
   endtask

   task automatic do_read(logic [15:0] addr);
      send_item(OP_READ, addr, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
   endtask

   task automatic do_write(logic [15:0] addr, logic [7:0] wdata);
      send_item(OP_WRITE, addr, wdata, 8'($urandom_range(0, 255)));
   endtask

   function automatic logic [15:0] pick_address();
      if ($urandom_range(0, 99) < 15)
         return 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 3))
         0:       return ADDR_DIV;
         1:       return ADDR_CNT;
         2:       return ADDR_RLD;
         default: return ADDR_CTL;
      endcase
   endfunction

   task automatic random_item();
      int unsigned r;
      logic [15:0] addr;
      logic [7:0]  wdata;
      logic [7:0]  cycles;
      r      = $urandom_range(0, 99);
      addr   = pick_address();
      wdata  = 8'($urandom_range(0, 255));
      cycles = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
         0, 1:    cycles = 8'hFF;
         2:       cycles = 8'h00;
         default: ;
      endcase
      if (addr == ADDR_CTL)
         wdata[ENABLE_BIT] = ($urandom_range(0, 4) != 0);
      else if (addr == ADDR_CNT && $urandom_range(0, 1) == 1)
         wdata = 8'($urandom_range(240, 255));   // close to wrapping
      if (r < 50)
         send_item(OP_TICK, addr, wdata, cycles);
      else if (r < 72)
         send_item(OP_READ, addr, wdata, cycles);
      else if (r < 95)
         send_item(OP_WRITE, addr, wdata, cycles);
      else
         send_item(OP_NONE, addr, wdata, cycles);
   endtask

   // Result side: ready held for random stretches, some of them long stalls
   initial begin
      int    hold;
      bit    rdy;
      int    r;
      string why;
      hold = 0;
      rdy  = 1'b1;
      rsp_chan.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (!sb.check_response(rsp_chan.read_data, rsp_chan.irq_request, why))
               report_mismatch(why);
         end
         if (hold == 0) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
               rdy  = 1'b1;
               hold = $urandom_range(30, 80);
            end else if (r < 65) begin
               rdy  = 1'b1;
               hold = $urandom_range(1, 4);
            end else if (r < 93) begin
               rdy  = 1'b0;
               hold = $urandom_range(1, 3);
            end else begin
               rdy  = 1'b0;
               hold = $urandom_range(10, 40);
            end
         end
         hold--;
         rsp_chan.ready <= rdy;
      end
   end

   initial begin
      mismatches  = 0;
      cycle_count = 0;
      send_burst  = 0;
      reset                   <= 1'b1;
      req_chan.valid          <= 1'b0;
      req_chan.op             <= OP_TICK;
      req_chan.address        <= '0;
      req_chan.write_data     <= '0;
      req_chan.elapsed_cycles <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers straight after reset, then unmapped reads and writes
      do_read(ADDR_DIV);
      do_read(ADDR_CNT);
      do_read(ADDR_RLD);
      do_read(ADDR_CTL);
      do_read(16'h0000);
      do_read(16'hFFFF);
      do_read(16'hFF08);
      do_write(16'h1234, 8'h55);
      send_item(OP_NONE, ADDR_CNT, 8'hAA, 8'hFF);
      // fastest period, counter at the top: several wraps in one tick
      do_write(ADDR_CTL, 8'hFD);
      do_write(ADDR_RLD, 8'hFE);
      do_write(ADDR_CNT, 8'hFF);
      do_tick(8'hFF);
      do_read(ADDR_CNT);
      // divider clear on any write
      do_tick(8'h00);
      do_write(ADDR_DIV, 8'hA5);
      do_read(ADDR_DIV);
      // stopped counter keeps its subcount while the divider runs
      do_write(ADDR_CTL, 8'h00);
      do_tick(8'hFF);
      // build a subcount just under the longest period, then switch to the shortest one
      do_write(ADDR_CTL, 8'h04);
      do_tick(8'hFF);
      do_tick(8'hFF);
      do_tick(8'hFF);
      do_tick(8'hF0);
      do_write(ADDR_CTL, 8'h05);
      do_tick(8'hFF);
      do_read(ADDR_CNT);

      repeat (RANDOM_ITEMS) random_item();
      req_chan.valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         report_mismatch($sformatf("%0d results never arrived", sb.pending()));

      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/hct_pkg.sv
hw/rtl/hct_if.sv
hw/rtl/hct_count_unit.sv
hw/rtl/handheld_console_timer.sv
hw/rtl/hct_checker.sv
bench/handheld_console_timer_test.sv
